// ===== rtl/kwssi_pkg.sv =====
// ----------------------------------------------------------------------------
// kwssi_pkg
// Shared sizes, types and register codes for the k-way sorted set
// intersection core.
// ----------------------------------------------------------------------------
package kwssi_pkg;

  // Sizes of the list store and of the result stream.
  localparam int MaxSlots   = 8;
  localparam int MaxElems   = 64;
  localparam int ValueW     = 16;
  localparam int MaxResults = 64;

  // Derived widths.
  localparam int SlotW   = $clog2(MaxSlots);
  localparam int PtrW    = $clog2(MaxElems);
  localparam int CntW    = $clog2(MaxElems + 1);
  localparam int AddrW   = SlotW + PtrW;
  localparam int Depth   = MaxSlots * MaxElems;
  localparam int NSlotW  = $clog2(MaxSlots + 1);
  localparam int ResW    = $clog2(MaxResults + 1);

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam int MaskW    = 8;
  localparam int UseW     = 4;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgConstrainedMask = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSlotsInUse      = 1'b1;

  // Request codes.
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqRun  = 1'b1;

  // Status codes.
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusNoSlots = 1'b1;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [SlotW-1:0]  slot_t;
  typedef logic [PtrW-1:0]   ptr_t;
  typedef logic [CntW-1:0]   cnt_t;

  // Read request from the walker towards the list store.
  typedef struct packed {
    logic  rd_en;
    slot_t rd_slot;
    ptr_t  rd_ptr;
    logic  clear;
  } walk_req_t;

  // One result item.
  typedef struct packed {
    value_t match_value;
    logic   match_valid;
    logic   last_result;
    logic   status;
  } res_t;

endpackage

// ===== rtl/kwssi_in_if.sv =====
// ----------------------------------------------------------------------------
// kwssi_in_if
// Request channel: load one element into a slot list, or run the
// intersection.
// ----------------------------------------------------------------------------
interface kwssi_in_if;
  import kwssi_pkg::*;

  logic   valid;
  logic   ready;
  logic   req_type;
  slot_t  slot_index;
  value_t feature_value;

  modport source (output valid, output req_type, output slot_index,
                  output feature_value, input ready);
  modport sink (input valid, input req_type, input slot_index,
                input feature_value, output ready);
endinterface

// ===== rtl/kwssi_out_if.sv =====
// ----------------------------------------------------------------------------
// kwssi_out_if
// Result channel: one matching feature index per item.
// ----------------------------------------------------------------------------
interface kwssi_out_if;
  import kwssi_pkg::*;

  logic   valid;
  logic   ready;
  value_t match_value;
  logic   match_valid;
  logic   last_result;
  logic   status;

  modport source (output valid, output match_value, output match_valid,
                  output last_result, output status, input ready);
  modport sink (input valid, input match_value, input match_valid,
                input last_result, input status, output ready);
endinterface

// ===== rtl/kwssi_ram.sv =====
// ----------------------------------------------------------------------------
// kwssi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwssi_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/kwssi_lists.sv =====
// ----------------------------------------------------------------------------
// kwssi_lists
// Per-slot list store: appends ascending elements, keeps the list counts and
// serves head reads for the walker.
// ----------------------------------------------------------------------------
module kwssi_lists (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ld_en_i,
  input  kwssi_pkg::slot_t    ld_slot_i,
  input  kwssi_pkg::value_t   ld_value_i,
  input  kwssi_pkg::walk_req_t req_i,
  output kwssi_pkg::cnt_t     cnt_o [kwssi_pkg::MaxSlots],
  output kwssi_pkg::value_t   rdata_o
);
  import kwssi_pkg::*;

  cnt_t   cnt_q  [MaxSlots];
  value_t last_q [MaxSlots];
  cnt_t   ld_cnt;
  logic   ld_ok;
  logic   wr_en;

  // A load is kept only if the slot exists, has room and the value ascends.
  assign ld_cnt = cnt_q[ld_slot_i];
  assign ld_ok  = (int'(ld_slot_i) < MaxSlots) && (int'(ld_cnt) < MaxElems) &&
                  ((ld_cnt == '0) || (ld_value_i > last_q[ld_slot_i]));
  assign wr_en  = ld_en_i && ld_ok;

  // List counts; every run clears them all.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MaxSlots; s++) begin
        cnt_q[s] <= '0;
      end
    end else if (req_i.clear) begin
      for (int s = 0; s < MaxSlots; s++) begin
        cnt_q[s] <= '0;
      end
    end else if (wr_en) begin
      cnt_q[ld_slot_i] <= ld_cnt + cnt_t'(1);
    end
  end

  // Last element of each list, for the ascending check.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      last_q[ld_slot_i] <= ld_value_i;
    end
  end

  assign cnt_o = cnt_q;

  // Element storage, one row of MaxElems words per slot.
  kwssi_ram #(
    .Width (ValueW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i ({ld_slot_i, ld_cnt[PtrW-1:0]}),
    .wdata_i (ld_value_i),
    .re_i    (req_i.rd_en),
    .raddr_i ({req_i.rd_slot, req_i.rd_ptr}),
    .rdata_o (rdata_o)
  );

endmodule

// ===== rtl/kwssi_walk.sv =====
// ----------------------------------------------------------------------------
// kwssi_walk
// Intersection sequencer: visits the constraining slots in turn with one
// head read and one compare per visit, and emits common values in order.
// ----------------------------------------------------------------------------
module kwssi_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [kwssi_pkg::MaxSlots-1:0] cons_i,
  input  kwssi_pkg::cnt_t      cnt_i [kwssi_pkg::MaxSlots],
  input  kwssi_pkg::value_t    rdata_i,
  output kwssi_pkg::walk_req_t req_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kwssi_pkg::res_t      res_o
);
  import kwssi_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCompare,
    StFlush
  } state_e;

  state_e               state_q, state_d;
  logic [MaxSlots-1:0]  cons_q, cons_d;
  logic [NSlotW-1:0]    ncons_q, ncons_d;
  logic [NSlotW-1:0]    agree_q, agree_d;
  slot_t                slot_q, slot_d;
  ptr_t                 ptr_q [MaxSlots];
  ptr_t                 ptr_d [MaxSlots];
  value_t               max_q, max_d;
  logic                 max_vld_q, max_vld_d;
  logic                 excl_q, excl_d;
  value_t               pend_val_q, pend_val_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [ResW-1:0]      nres_q, nres_d;
  logic                 err_q, err_d;
  logic                 out_vld_q, out_vld_d;
  res_t                 res_q, res_d;

  logic                 out_free;
  logic [CntW-1:0]      ptr_inc;
  logic                 exhausted;
  logic                 below, above;
  logic [NSlotW-1:0]    agree_n;
  logic [NSlotW-1:0]    popcnt;
  logic                 any_empty;
  slot_t                first_slot;
  slot_t                next_slot;
  walk_req_t            req;

  // Count of constraining slots, first one, and any that is empty.
  always_comb begin
    popcnt     = '0;
    any_empty  = 1'b0;
    first_slot = '0;
    for (int s = MaxSlots - 1; s >= 0; s--) begin
      if (cons_i[s]) begin
        popcnt     = popcnt + NSlotW'(1);
        first_slot = SlotW'(s);
        if (cnt_i[s] == '0) begin
          any_empty = 1'b1;
        end
      end
    end
  end

  // Next constraining slot after the current one, wrapping round.
  always_comb begin
    next_slot = slot_q;
    for (int i = MaxSlots - 1; i >= 1; i--) begin
      if (cons_q[(int'(slot_q) + i) % MaxSlots]) begin
        next_slot = SlotW'((int'(slot_q) + i) % MaxSlots);
      end
    end
  end

  // Compare of the current head against the running maximum. After a match
  // the old maximum itself counts as too small, so every list steps past it.
  assign ptr_inc   = {1'b0, ptr_q[slot_q]} + CntW'(1);
  assign exhausted = ptr_inc >= cnt_i[slot_q];
  assign below     = max_vld_q && ((rdata_i < max_q) || (excl_q && rdata_i == max_q));
  assign above     = !max_vld_q || (rdata_i > max_q);
  assign agree_n   = above ? NSlotW'(1) : agree_q + NSlotW'(1);
  assign out_free  = !out_vld_q || out_ready_i;

  // Sequencer next-state logic.
  always_comb begin
    state_d    = state_q;
    cons_d     = cons_q;
    ncons_d    = ncons_q;
    agree_d    = agree_q;
    slot_d     = slot_q;
    ptr_d      = ptr_q;
    max_d      = max_q;
    max_vld_d  = max_vld_q;
    excl_d     = excl_q;
    pend_val_d = pend_val_q;
    pend_vld_d = pend_vld_q;
    nres_d     = nres_q;
    err_d      = err_q;
    out_vld_d  = out_vld_q;
    res_d      = res_q;
    req        = '0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (start_i) begin
          cons_d     = cons_i;
          ncons_d    = popcnt;
          agree_d    = '0;
          slot_d     = first_slot;
          max_vld_d  = 1'b0;
          excl_d     = 1'b0;
          pend_vld_d = 1'b0;
          nres_d     = '0;
          err_d      = (cons_i == '0);
          for (int s = 0; s < MaxSlots; s++) begin
            ptr_d[s] = '0;
          end
          if ((cons_i == '0) || any_empty) begin
            state_d = StFlush;
          end else begin
            state_d = StRead;
          end
        end
      end

      StRead: begin
        req.rd_en   = 1'b1;
        req.rd_slot = slot_q;
        req.rd_ptr  = ptr_q[slot_q];
        state_d     = StCompare;
      end

      StCompare: begin
        if (below) begin
          // Head too small: step this list on, or stop at its end.
          ptr_d[slot_q] = ptr_inc[PtrW-1:0];
          state_d       = exhausted ? StFlush : StRead;
        end else if (agree_n == ncons_q) begin
          // Every constraining head equals the maximum: a match. The
          // previous match leaves through the output register first.
          if (!pend_vld_q || out_free) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              res_d     = '{match_value: pend_val_q, match_valid: 1'b1,
                            last_result: 1'b0, status: StatusOk};
            end
            pend_val_d    = rdata_i;
            pend_vld_d    = 1'b1;
            nres_d        = nres_q + ResW'(1);
            max_d         = rdata_i;
            max_vld_d     = 1'b1;
            excl_d        = 1'b1;
            agree_d       = '0;
            ptr_d[slot_q] = ptr_inc[PtrW-1:0];
            if (exhausted || (nres_q + ResW'(1) == ResW'(MaxResults))) begin
              state_d = StFlush;
            end else begin
              state_d = StRead;
            end
          end
        end else begin
          // Head equal to or above the maximum: move to the next list.
          if (above) begin
            max_d     = rdata_i;
            max_vld_d = 1'b1;
            excl_d    = 1'b0;
          end
          agree_d = agree_n;
          slot_d  = next_slot;
          state_d = StRead;
        end
      end

      StFlush: begin
        // Final item of the run, then clear all lists.
        if (out_free) begin
          out_vld_d = 1'b1;
          if (pend_vld_q) begin
            res_d = '{match_value: pend_val_q, match_valid: 1'b1,
                      last_result: 1'b1, status: StatusOk};
          end else begin
            res_d = '{match_value: '0, match_valid: 1'b0, last_result: 1'b1,
                      status: err_q ? StatusNoSlots : StatusOk};
          end
          req.clear = 1'b1;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cons_q     <= '0;
      ncons_q    <= '0;
      agree_q    <= '0;
      slot_q     <= '0;
      for (int s = 0; s < MaxSlots; s++) begin
        ptr_q[s] <= '0;
      end
      max_vld_q  <= 1'b0;
      excl_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      nres_q     <= '0;
      err_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cons_q     <= cons_d;
      ncons_q    <= ncons_d;
      agree_q    <= agree_d;
      slot_q     <= slot_d;
      ptr_q      <= ptr_d;
      max_vld_q  <= max_vld_d;
      excl_q     <= excl_d;
      pend_vld_q <= pend_vld_d;
      nres_q     <= nres_d;
      err_q      <= err_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    max_q      <= max_d;
    pend_val_q <= pend_val_d;
    res_q      <= res_d;
  end

  assign req_o       = req;
  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/k_way_sorted_set_intersection_core.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_set_intersection_core
// Intersects up to eight ascending lists of feature indices loaded item by
// item, and streams the common indices in ascending order.
// ----------------------------------------------------------------------------
// Loads may follow each other in every cycle while no run is in progress.
// A run item walks the lists of the constraining slots with a single
// list-store read port and one comparator: every visit of a list head is a
// read state followed by a compare state, and the block takes no new item
// until the run has ended. Results leave through an output register, so a
// stalled result holds the walk only when the next match is found or the
// run ends. Each run gives at most 64 matches and then clears all lists.
module k_way_sorted_set_intersection_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  kwssi_in_if.sink                            in_i,
  kwssi_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [kwssi_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [kwssi_pkg::CfgDataW-1:0]      cfg_data_i
);
  import kwssi_pkg::*;

  logic [MaskW-1:0]    mask_q;
  logic [UseW-1:0]     use_q;
  logic [MaxSlots-1:0] cons;
  logic                busy;
  logic                in_acc;
  cnt_t                cnt [MaxSlots];
  value_t              rdata;
  walk_req_t           req;
  res_t                res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskW'(255);
      use_q  <= UseW'(MaxSlots);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgConstrainedMask: mask_q <= cfg_data_i[MaskW-1:0];
        CfgSlotsInUse:      use_q  <= cfg_data_i[UseW-1:0];
        default: ;
      endcase
    end
  end

  // A slot constrains when its mask bit is set and it lies below the
  // number of slots in use.
  always_comb begin
    for (int s = 0; s < MaxSlots; s++) begin
      cons[s] = (s < MaskW) && mask_q[s % MaskW] && (s < int'(use_q));
    end
  end

  // Input handshake.
  assign in_i.ready = !busy;
  assign in_acc     = in_i.valid && !busy;

  kwssi_lists u_lists (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_en_i    (in_acc && (in_i.req_type == ReqLoad)),
    .ld_slot_i  (in_i.slot_index),
    .ld_value_i (in_i.feature_value),
    .req_i      (req),
    .cnt_o      (cnt),
    .rdata_o    (rdata)
  );

  kwssi_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc && (in_i.req_type == ReqRun)),
    .cons_i      (cons),
    .cnt_i       (cnt),
    .rdata_i     (rdata),
    .req_o       (req),
    .busy_o      (busy),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  // Result channel payload.
  assign out_o.match_value = res.match_value;
  assign out_o.match_valid = res.match_valid;
  assign out_o.last_result = res.last_result;
  assign out_o.status      = res.status;

endmodule
